>>> sv/bcm_pkg.sv
// Shared types and constants for the banked cartridge mapper with clock.
// No dependencies; imported by banked_cartridge_mapper_rtc_top.
package bcm_pkg;

    localparam int ROM_WINDOW_BYTES = 16384;
    localparam int RAM_WINDOW_BYTES = 8192;
    localparam int ROM_OFS_W        = $clog2(ROM_WINDOW_BYTES);
    localparam int RAM_OFS_W        = $clog2(RAM_WINDOW_BYTES);
    localparam int ROM_BANK_W       = 7;
    localparam int MAP_ADDR_W       = 21;
    localparam int CFG_IDX_W        = 1;

    typedef enum logic [2:0] {
        OP_ROM_READ  = 3'd0,
        OP_CTRL_WR   = 3'd1,
        OP_RAM_READ  = 3'd2,
        OP_RAM_WRITE = 3'd3,
        OP_TICK      = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OOB      = 3'd1,
        ST_DISABLED = 3'd2,
        ST_NO_RAM   = 3'd3,
        ST_NO_CLOCK = 3'd4,
        ST_BAD_SEL  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        TGT_NONE  = 2'd0,
        TGT_ROM   = 2'd1,
        TGT_RAM   = 2'd2,
        TGT_CLOCK = 2'd3
    } t_target;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HAS_RAM   = 1'b0,
        CFG_HAS_CLOCK = 1'b1
    } t_cfg_idx;

    // control write regions, address bits 14:13 below 0x8000
    localparam logic [1:0] CTL_ENABLE = 2'd0;
    localparam logic [1:0] CTL_ROMBNK = 2'd1;
    localparam logic [1:0] CTL_RAMSEL = 2'd2;
    localparam logic [1:0] CTL_LATCH  = 2'd3;

    localparam logic [3:0] ENABLE_KEY = 4'hA;

    localparam logic [3:0] RTC_SEC  = 4'h8;
    localparam logic [3:0] RTC_MIN  = 4'h9;
    localparam logic [3:0] RTC_HOUR = 4'hA;
    localparam logic [3:0] RTC_DAYL = 4'hB;
    localparam logic [3:0] RTC_CTRL = 4'hC;

    localparam logic [5:0] SEC_MAX  = 6'd59;
    localparam logic [5:0] MIN_MAX  = 6'd59;
    localparam logic [4:0] HOUR_MAX = 5'd23;
    localparam logic [8:0] DAY_MAX  = 9'd511;

    typedef struct packed {
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [8:0] days;
        logic       halted;
        logic       overflowed;
    } t_clock;

    typedef struct packed {
        t_status                 status;
        t_target                 target;
        logic [MAP_ADDR_W-1:0]   mapped_address;
        logic [7:0]              read_data;
    } t_result;

endpackage

>>> sv/banked_cartridge_mapper_rtc_top.sv
// Banked ROM/RAM cartridge mapper with real time clock: top level.
// Depends on bcm_pkg.
//
// Each input transaction (ROM read, control write, RAM/clock access or
// one-second tick) is decoded combinationally against the bank and clock
// registers and its one result is placed in an output register; one
// transaction can be taken every cycle while o_in_stall is low. A skid
// register behind the output lets one further transaction in while a result
// is stalled; o_in_stall rises only when both are full. Configuration writes
// (has_ram, has_clock) are always ready and must be issued while idle.
module banked_cartridge_mapper_rtc_top
    import bcm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_opcode,
    input  logic [15:0]           i_address,
    input  logic [7:0]            i_write_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_status,
    output logic [1:0]            o_target,
    output logic [MAP_ADDR_W-1:0] o_mapped_address,
    output logic [7:0]            o_read_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic                  i_cfg_data
);

    logic                  r_has_ram, r_has_clock;
    logic                  r_access_enable, n_access_enable;
    logic [ROM_BANK_W-1:0] r_rom_bank, n_rom_bank;
    logic [3:0]            r_ram_sel, n_ram_sel;
    logic [7:0]            r_latch_last, n_latch_last;
    t_clock                r_live, n_live;
    t_clock                r_latched, n_latched;

    logic    r_ov, r_sv;
    t_result r_out, r_skid;
    t_result w_res;

    logic    w_acc, w_take;
    t_clock  w_tick;
    logic    w_sec_c, w_min_c, w_hour_c;
    logic    w_ram_bank, w_rtc_reg;
    logic [7:0] w_rtc_rd;

    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_take     = r_ov && !i_out_stall;
    assign o_in_stall = r_sv;
    assign o_cfg_ready = 1'b1;

    assign w_ram_bank = (r_ram_sel[3:2] == 2'b00);
    assign w_rtc_reg  = (r_ram_sel >= RTC_SEC) && (r_ram_sel <= RTC_CTRL);

    // one-second advance of the live clock
    always_comb begin
        w_tick   = r_live;
        w_sec_c  = (r_live.seconds == SEC_MAX);
        w_min_c  = (r_live.minutes == MIN_MAX);
        w_hour_c = (r_live.hours == HOUR_MAX);
        w_tick.seconds = w_sec_c ? '0 : r_live.seconds + 6'd1;
        if (w_sec_c) begin
            w_tick.minutes = w_min_c ? '0 : r_live.minutes + 6'd1;
            if (w_min_c) begin
                w_tick.hours = w_hour_c ? '0 : r_live.hours + 5'd1;
                if (w_hour_c) begin
                    w_tick.days = r_live.days + 9'd1;
                    if (r_live.days == DAY_MAX) begin
                        w_tick.overflowed = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        unique case (r_ram_sel)
            RTC_SEC:  w_rtc_rd = {2'b00, r_latched.seconds};
            RTC_MIN:  w_rtc_rd = {2'b00, r_latched.minutes};
            RTC_HOUR: w_rtc_rd = {3'b000, r_latched.hours};
            RTC_DAYL: w_rtc_rd = r_latched.days[7:0];
            default:  w_rtc_rd = {r_latched.overflowed, r_latched.halted, 5'b00000,
                                  r_latched.days[8]};
        endcase
    end

    always_comb begin
        n_access_enable = r_access_enable;
        n_rom_bank      = r_rom_bank;
        n_ram_sel       = r_ram_sel;
        n_latch_last    = r_latch_last;
        n_live          = r_live;
        n_latched       = r_latched;
        w_res.status         = ST_OK;
        w_res.target         = TGT_NONE;
        w_res.mapped_address = '0;
        w_res.read_data      = '0;
        unique case (i_opcode)
            OP_ROM_READ: begin
                if (i_address[15]) begin
                    w_res.status = ST_OOB;
                end else if (!i_address[14]) begin
                    w_res.target         = TGT_ROM;
                    w_res.mapped_address = MAP_ADDR_W'(i_address);
                end else begin
                    w_res.target         = TGT_ROM;
                    w_res.mapped_address = {r_rom_bank, i_address[ROM_OFS_W-1:0]};
                end
            end
            OP_CTRL_WR: begin
                if (i_address[15]) begin
                    w_res.status = ST_OOB;
                end else begin
                    unique case (i_address[14:13])
                        CTL_ENABLE: n_access_enable = (i_write_data[3:0] == ENABLE_KEY);
                        CTL_ROMBNK: n_rom_bank = (i_write_data[6:0] == '0) ?
                                                 ROM_BANK_W'(1) : i_write_data[6:0];
                        CTL_RAMSEL: n_ram_sel = i_write_data[3:0];
                        default: begin
                            if (r_latch_last == 8'h00 && i_write_data == 8'h01) begin
                                n_latched = r_live;
                            end
                            n_latch_last = i_write_data;
                        end
                    endcase
                end
            end
            OP_RAM_READ, OP_RAM_WRITE: begin
                priority if (!r_access_enable) begin
                    w_res.status = ST_DISABLED;
                end else if (i_address[15:RAM_OFS_W] != '0) begin
                    w_res.status = ST_OOB;
                end else if (w_ram_bank) begin
                    if (!r_has_ram) begin
                        w_res.status = ST_NO_RAM;
                    end else begin
                        w_res.target         = TGT_RAM;
                        w_res.mapped_address = MAP_ADDR_W'({r_ram_sel[1:0],
                                                            i_address[RAM_OFS_W-1:0]});
                    end
                end else if (w_rtc_reg) begin
                    if (!r_has_clock) begin
                        w_res.status = ST_NO_CLOCK;
                    end else begin
                        w_res.target = TGT_CLOCK;
                        if (i_opcode == OP_RAM_READ) begin
                            w_res.read_data = w_rtc_rd;
                        end else begin
                            unique case (r_ram_sel)
                                RTC_SEC:  n_live.seconds = i_write_data[5:0];
                                RTC_MIN:  n_live.minutes = i_write_data[5:0];
                                RTC_HOUR: n_live.hours   = i_write_data[4:0];
                                RTC_DAYL: n_live.days[7:0] = i_write_data;
                                default: begin
                                    n_live.days[8]    = i_write_data[0];
                                    n_live.halted     = i_write_data[6];
                                    n_live.overflowed = i_write_data[7];
                                end
                            endcase
                        end
                    end
                end else begin
                    w_res.status = ST_BAD_SEL;
                end
            end
            OP_TICK: begin
                if (!r_live.halted) begin
                    n_live = w_tick;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_ram       <= 1'b1;
            r_has_clock     <= 1'b1;
            r_access_enable <= 1'b0;
            r_rom_bank      <= ROM_BANK_W'(1);
            r_ram_sel       <= '0;
            r_latch_last    <= 8'hFF;
            r_live          <= '0;
            r_latched       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_HAS_RAM:   r_has_ram   <= i_cfg_data;
                    default:       r_has_clock <= i_cfg_data;
                endcase
            end
            if (w_acc) begin
                r_access_enable <= n_access_enable;
                r_rom_bank      <= n_rom_bank;
                r_ram_sel       <= n_ram_sel;
                r_latch_last    <= n_latch_last;
                r_live          <= n_live;
                r_latched       <= n_latched;
            end
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_take) begin
                r_sv <= 1'b0;
            end
        end else if (w_acc) begin
            if (!r_ov || w_take) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (w_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_acc) begin
            if (!r_ov || w_take) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_out_valid      = r_ov;
    assign o_status         = r_out.status;
    assign o_target         = r_out.target;
    assign o_mapped_address = r_out.mapped_address;
    assign o_read_data      = r_out.read_data;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid full with output register empty");

    a_rom_bank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rom_bank != '0)
        else $error("ROM bank register holds zero");

    a_rom_bank_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_opcode == OP_CTRL_WR && i_address[15:13] == 3'b001)
        |=> (r_rom_bank == (($past(i_write_data[6:0]) == '0) ?
                            ROM_BANK_W'(1) : $past(i_write_data[6:0]))))
        else $error("ROM bank write not taken");

    a_mapped_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.target != TGT_NONE) |-> (r_out.status == ST_OK))
        else $error("target given with an error status");

    a_halted_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_opcode == OP_TICK && r_live.halted) |=> $stable(r_live))
        else $error("halted clock advanced");

endmodule

>>> sim/tb.sv
// Testbench for banked_cartridge_mapper_rtc_top: directed and random bus transactions,
// with every result checked against a transaction-level model of bank mapping and clock.
// Depends on bcm_pkg and the RTL top level.
import bcm_pkg::*;

class mapper_scoreboard;
    bit         has_ram;
    bit         has_clock;
    bit         access_en;
    logic [6:0] rom_bank;
    logic [3:0] ram_sel;
    logic [7:0] latch_prev;
    t_clock     live;
    t_clock     snap;
    t_result    expected_q[$];
    int         errors;
    int         reported;
    int         checked;

    function new();
        has_ram    = 1'b1;
        has_clock  = 1'b1;
        access_en  = 1'b0;
        rom_bank   = 7'd1;
        ram_sel    = 4'd0;
        latch_prev = 8'hFF;
        live       = '0;
        snap       = '0;
        errors     = 0;
        reported   = 0;
        checked    = 0;
    endfunction

    function void set_config(t_cfg_idx idx, bit v);
        if (idx == CFG_HAS_RAM) has_ram = v;
        else has_clock = v;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_access(logic [2:0] op, logic [15:0] addr, logic [7:0] data);
        t_result r;
        bit      carry;
        r = '0;
        case (op)
            OP_ROM_READ: begin
                if (addr < ROM_WINDOW_BYTES) begin
                    r.target = TGT_ROM;
                    r.mapped_address = MAP_ADDR_W'(addr);
                end else if (addr < 2 * ROM_WINDOW_BYTES) begin
                    r.target = TGT_ROM;
                    r.mapped_address = {rom_bank, addr[ROM_OFS_W-1:0]};
                end else begin
                    r.status = ST_OOB;
                end
            end
            OP_CTRL_WR: begin
                if (addr >= 2 * ROM_WINDOW_BYTES) begin
                    r.status = ST_OOB;
                end else begin
                    case (addr[14:13])
                        CTL_ENABLE: access_en = (data[3:0] == ENABLE_KEY);
                        CTL_ROMBNK: rom_bank = (data[6:0] == 7'd0) ? 7'd1 : data[6:0];
                        CTL_RAMSEL: ram_sel = data[3:0];
                        CTL_LATCH: begin
                            if (latch_prev == 8'h00 && data == 8'h01) snap = live;
                            latch_prev = data;
                        end
                    endcase
                end
            end
            OP_RAM_READ, OP_RAM_WRITE: begin
                if (!access_en) begin
                    r.status = ST_DISABLED;
                end else if (addr >= RAM_WINDOW_BYTES) begin
                    r.status = ST_OOB;
                end else if (ram_sel < 4) begin
                    if (!has_ram) begin
                        r.status = ST_NO_RAM;
                    end else begin
                        r.target = TGT_RAM;
                        r.mapped_address = MAP_ADDR_W'({ram_sel[1:0],
                                                        addr[RAM_OFS_W-1:0]});
                    end
                end else if (ram_sel >= RTC_SEC && ram_sel <= RTC_CTRL) begin
                    if (!has_clock) begin
                        r.status = ST_NO_CLOCK;
                    end else if (op == OP_RAM_READ) begin
                        r.target = TGT_CLOCK;
                        case (ram_sel)
                            RTC_SEC:  r.read_data = {2'b00, snap.seconds};
                            RTC_MIN:  r.read_data = {2'b00, snap.minutes};
                            RTC_HOUR: r.read_data = {3'b000, snap.hours};
                            RTC_DAYL: r.read_data = snap.days[7:0];
                            default: begin
                                r.read_data = {snap.overflowed, snap.halted, 5'b00000,
                                               snap.days[8]};
                            end
                        endcase
                    end else begin
                        r.target = TGT_CLOCK;
                        case (ram_sel)
                            RTC_SEC:  live.seconds = data[5:0];
                            RTC_MIN:  live.minutes = data[5:0];
                            RTC_HOUR: live.hours = data[4:0];
                            RTC_DAYL: live.days[7:0] = data;
                            default: begin
                                live.days[8]    = data[0];
                                live.halted     = data[6];
                                live.overflowed = data[7];
                            end
                        endcase
                    end
                end else begin
                    r.status = ST_BAD_SEL;
                end
            end
            OP_TICK: begin
                if (!live.halted) begin
                    // values above the normal maximum wrap at their width, no carry
                    carry = (live.seconds == SEC_MAX);
                    live.seconds = carry ? 6'd0 : live.seconds + 6'd1;
                    if (carry) begin
                        carry = (live.minutes == MIN_MAX);
                        live.minutes = carry ? 6'd0 : live.minutes + 6'd1;
                        if (carry) begin
                            carry = (live.hours == HOUR_MAX);
                            live.hours = carry ? 5'd0 : live.hours + 5'd1;
                            if (carry) begin
                                if (live.days == DAY_MAX) live.overflowed = 1'b1;
                                live.days = live.days + 9'd1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        expected_q.push_back(r);
    endfunction

    function void check_result(logic [2:0] st, logic [1:0] tg, logic [MAP_ADDR_W-1:0] ma,
                               logic [7:0] rd);
        t_result want;
        checked++;
        if (expected_q.size() == 0) begin
            errors++;
            if (reported < 10) begin
                reported++;
                $display("unexpected result: status %0d target %0d addr %h data %h",
                         st, tg, ma, rd);
            end
            return;
        end
        want = expected_q.pop_front();
        if (st !== want.status || tg !== want.target || ma !== want.mapped_address ||
            rd !== want.read_data) begin
            errors++;
            if (reported < 10) begin
                reported++;
                $display("mismatch on result %0d: expected status %0d target %0d addr %h data %h",
                         checked, want.status, want.target, want.mapped_address,
                         want.read_data);
                $display("    got status %0d target %0d addr %h data %h", st, tg, ma, rd);
            end
        end
    endfunction
endclass

module tb;
    localparam int QUIET_LIMIT     = 4000;
    localparam int ITEMS_PER_PHASE = 225;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    logic [2:0]            opcode         = '0;
    logic [15:0]           address        = '0;
    logic [7:0]            write_data     = '0;
    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic [2:0]            status;
    logic [1:0]            target;
    logic [MAP_ADDR_W-1:0] mapped_address;
    logic [7:0]            read_data;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = CFG_HAS_RAM;
    logic                  cfg_data       = 1'b0;

    int                    in_idle_pct    = 0;
    int                    out_stall_pct  = 0;
    int                    items_sent     = 0;
    mapper_scoreboard      board;

    banked_cartridge_mapper_rtc_top u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_opcode         (opcode),
        .i_address        (address),
        .i_write_data     (write_data),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_status         (status),
        .o_target         (target),
        .o_mapped_address (mapped_address),
        .o_read_data      (read_data),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            board.check_result(status, target, mapped_address, read_data);
        end
    end

    task automatic send_item(logic [2:0] op, logic [15:0] addr, logic [7:0] data);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        address    <= addr;
        write_data <= data;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_access(op, addr, data);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_config(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [15:0] region_addr(logic [1:0] region);
        return {1'b0, region, 13'($urandom)};
    endfunction

    function automatic logic [15:0] rand_ram_addr();
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'($urandom_range(RAM_WINDOW_BYTES - 1));
    endfunction

    function automatic logic [7:0] rand_sel_byte();
        logic [7:0] b;
        b = 8'($urandom);
        case ($urandom_range(4))
            0, 1:    b[3:0] = 4'($urandom_range(3));
            2, 3:    b[3:0] = 4'($urandom_range(RTC_CTRL, RTC_SEC));
            default: ;
        endcase
        return b;
    endfunction

    // near-wrap values so that carries, overflow and wrap without carry get exercised
    function automatic logic [7:0] clock_value(logic [3:0] sel, bit brink);
        logic [7:0] v;
        v = 8'($urandom);
        if (brink) begin
            case (sel)
                RTC_SEC, RTC_MIN: v = 8'(SEC_MAX);
                RTC_HOUR:         v = 8'(HOUR_MAX);
                RTC_DAYL:         v = 8'hFF;
                default: begin
                    v[6] = 1'b0;
                    v[0] = 1'b1;
                end
            endcase
        end else if ($urandom_range(2) != 0) begin
            case (sel)
                RTC_SEC, RTC_MIN: v[5:0] = 6'($urandom_range(63, 57));
                RTC_HOUR:         v[4:0] = 5'($urandom_range(31, 21));
                RTC_DAYL:         v = 8'hFF;
                default:          v[6] = ($urandom_range(3) == 0);
            endcase
        end
        return v;
    endfunction

    task automatic clock_session();
        bit         brink;
        logic [3:0] sel;
        brink = ($urandom_range(3) == 0);
        send_item(OP_CTRL_WR, region_addr(CTL_ENABLE),
                  ($urandom_range(9) == 0) ? 8'($urandom) : {4'($urandom), ENABLE_KEY});
        for (int r = RTC_SEC; r <= RTC_CTRL; r++) begin
            if (brink || $urandom_range(1) == 1) begin
                sel = 4'(r);
                send_item(OP_CTRL_WR, region_addr(CTL_RAMSEL), {4'($urandom), sel});
                send_item(OP_RAM_WRITE, rand_ram_addr(), clock_value(sel, brink));
            end
        end
        repeat ($urandom_range(4, 1)) send_item(OP_TICK, 16'($urandom), 8'($urandom));
        send_item(OP_CTRL_WR, region_addr(CTL_LATCH), 8'h00);
        send_item(OP_CTRL_WR, region_addr(CTL_LATCH),
                  ($urandom_range(7) == 0) ? 8'($urandom) : 8'h01);
        repeat ($urandom_range(5, 1)) begin
            send_item(OP_CTRL_WR, region_addr(CTL_RAMSEL), rand_sel_byte());
            send_item(OP_RAM_READ, rand_ram_addr(), 8'($urandom));
        end
    endtask

    task automatic random_item();
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
        int          pick;
        pick = $urandom_range(99);
        addr = 16'($urandom);
        data = 8'($urandom);
        if (pick < 20) begin
            op = OP_ROM_READ;
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(3))
                    0:       addr = 16'h3FFF;
                    1:       addr = 16'h4000;
                    2:       addr = 16'h7FFF;
                    default: addr = 16'h8000;
                endcase
            end
        end else if (pick < 40) begin
            op = OP_CTRL_WR;
            if ($urandom_range(7) != 0) addr = region_addr(2'($urandom));
            case (addr[14:13])
                CTL_ENABLE: if ($urandom_range(1) == 1) data[3:0] = ENABLE_KEY;
                CTL_RAMSEL: data = rand_sel_byte();
                CTL_LATCH:  if ($urandom_range(2) != 0) data = 8'($urandom_range(1));
                default:    ;
            endcase
        end else if (pick < 80) begin
            op = (pick < 60) ? OP_RAM_READ : OP_RAM_WRITE;
            addr = rand_ram_addr();
        end else if (pick < 96) begin
            op = OP_TICK;
        end else begin
            op = 3'($urandom_range(7, 5));
        end
        send_item(op, addr, data);
    endtask

    initial begin
        int quiet;
        quiet = 0;
        wait (rst_n);
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int target_items;
        board = new();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            write_cfg(CFG_HAS_RAM, !(ph == 2 || ph == 3));
            write_cfg(CFG_HAS_CLOCK, !(ph == 1 || ph == 3));
            case (ph)
                1:       begin in_idle_pct = 85; out_stall_pct = 0;  end
                2:       begin in_idle_pct = 0;  out_stall_pct = 85; end
                3:       begin in_idle_pct = 19; out_stall_pct = 19; end
                default: begin in_idle_pct = 0;  out_stall_pct = 0;  end
            endcase
            if (ph == 0) begin
                send_item(OP_ROM_READ, 16'h0000, 8'h00);
                send_item(OP_ROM_READ, 16'h7FFF, 8'hFF);
                send_item(OP_ROM_READ, 16'h8000, 8'h00);
                send_item(OP_RAM_READ, 16'h0000, 8'h00);
                send_item(OP_CTRL_WR, 16'h1FFF, 8'h5A);
                send_item(OP_CTRL_WR, 16'h2000, 8'h80);
                send_item(OP_ROM_READ, 16'h4000, 8'h00);
                send_item(OP_CTRL_WR, 16'h3FFF, 8'h7F);
                send_item(OP_ROM_READ, 16'h7FFF, 8'h00);
                send_item(OP_CTRL_WR, 16'hFFFF, 8'hFF);
                send_item(OP_RAM_WRITE, 16'h2000, 8'hFF);
                send_item(OP_CTRL_WR, 16'h4000, 8'h03);
                send_item(OP_RAM_READ, 16'h1FFF, 8'h00);
                send_item(OP_CTRL_WR, 16'h5FFF, 8'h0F);
                send_item(OP_RAM_WRITE, 16'h0000, 8'hAA);
                send_item(OP_CTRL_WR, 16'h4000, {4'h0, RTC_CTRL});
                send_item(OP_RAM_WRITE, 16'h0000, 8'hC1);
                send_item(OP_TICK, 16'h0000, 8'h00);
                send_item(OP_CTRL_WR, 16'h6000, 8'h00);
                send_item(OP_CTRL_WR, 16'h7FFF, 8'h01);
                send_item(OP_RAM_READ, 16'h0000, 8'h00);
                send_item(OP_RAM_WRITE, 16'h0000, 8'h00);
                send_item(OP_CTRL_WR, 16'h4000, {4'h0, RTC_SEC});
                send_item(OP_RAM_WRITE, 16'h1FFF, 8'h3F);
                send_item(OP_TICK, 16'hFFFF, 8'hFF);
                send_item(3'd7, 16'hFFFF, 8'hFF);
            end
            target_items = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target_items) begin
                if ($urandom_range(9) < 3) clock_session();
                else random_item();
            end
        end
        drain();
        $display("%0d transactions over five idle/stall phases, %0d results checked, %0d bad",
                 items_sent, board.checked, board.errors);
        $display("has_ram and has_clock each run both set and clear");
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
